FILE: hdl/bdq_pkg.sv
// Shared types and codes for the bounded deque with search.
package bdq_pkg;

  localparam int unsigned DEPTH_DEF       = 32;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // Operation codes carried in the mode field.
  localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [2:0] MODE_POP_BACK   = 3'd3;
  localparam logic [2:0] MODE_SEARCH     = 3'd4;
  localparam logic [2:0] MODE_TRAVERSE   = 3'd5;

  // Result kinds.
  localparam logic [2:0] KIND_DONE      = 3'd0;
  localparam logic [2:0] KIND_EMPTY_ERR = 3'd1;
  localparam logic [2:0] KIND_FULL_ERR  = 3'd2;
  localparam logic [2:0] KIND_LISTED    = 3'd3;
  localparam logic [2:0] KIND_MATCH     = 3'd4;
  localparam logic [2:0] KIND_NO_MATCH  = 3'd5;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] item_value;
  } in_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] entry_value;
    logic [5:0]         position;
    logic [5:0]         occupancy;
    logic               last;
  } out_t;

endpackage

FILE: hdl/bdq_store.sv
// Entry store: ring of words with one write port and one registered read port.
module bdq_store import bdq_pkg::*; #(
  parameter int unsigned DEPTH       = DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int unsigned IW          = $clog2(DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [IW-1:0]          waddr_i,
  input  logic [VALUE_WIDTH-1:0] wdata_i,
  input  logic [IW-1:0]          raddr_i,
  output logic [VALUE_WIDTH-1:0] rdata_o
);

  logic [VALUE_WIDTH-1:0] mem [DEPTH];
  logic [VALUE_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/bounded_deque_with_search.sv
// Bounded double-ended queue with linear search over a ring store.
// Push, an error or an unused mode: one result in the cycle after the transfer; busy never rises.
// Pop: busy for one cycle while the store read lands in S_POP; the result is then registered in res_q.
// Search and traverse on N entries: busy while the entries are walked (and, for search, the flush state),
// one entry per cycle, set by the single read port of the store; results are registered behind the walk.
// Reset clears head and count (store empty); store contents are undefined until written.
module bounded_deque_with_search import bdq_pkg::*; #(
  parameter int unsigned DEPTH       = DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  cmd_i,
  output logic result_valid_o,
  output out_t result_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SCAN,
    S_FLUSH
  } state_e;

  state_e                 state_q, state_d;
  logic [IW-1:0]          head_q, head_d;
  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          pos_q, pos_d;
  logic                   trav_q, trav_d;
  logic [VALUE_WIDTH-1:0] key_q, key_d;
  logic                   pend_q, pend_d;
  logic [VALUE_WIDTH-1:0] pend_val_q, pend_val_d;
  logic [CW-1:0]          pend_pos_q, pend_pos_d;
  logic                   res_valid_q, res_valid_d;
  out_t                   res_q, res_d;

  logic                   we;
  logic [IW-1:0]          waddr;
  logic [IW-1:0]          raddr;
  logic [VALUE_WIDTH-1:0] rdata;
  logic [VALUE_WIDTH-1:0] in_key;
  logic signed [EW-1:0]   in_ext;
  logic                   full, empty, at_end;
  logic [IW-1:0]          head_inc, head_dec;

  function automatic logic [IW-1:0] slot(input logic [IW-1:0] h, input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(off);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[IW-1:0];
  endfunction

  function automatic logic [31:0] to_out(input logic [VALUE_WIDTH-1:0] v);
    logic [EW-1:0] w;
    w = EW'(v);
    return w[31:0];
  endfunction

  bdq_store #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .IW          (IW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (in_key),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign in_ext   = EW'(cmd_i.item_value);
  assign in_key   = in_ext[VALUE_WIDTH-1:0];
  assign full     = (count_q == CW'(DEPTH));
  assign empty    = (count_q == '0);
  assign at_end   = (pos_q == count_q);
  assign head_inc = (head_q == IW'(DEPTH - 1)) ? '0 : IW'(head_q + 1'b1);
  assign head_dec = (head_q == '0) ? IW'(DEPTH - 1) : IW'(head_q - 1'b1);
  assign busy     = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    pos_d       = pos_q;
    trav_d      = trav_q;
    key_d       = key_q;
    pend_d      = pend_q;
    pend_val_d  = pend_val_q;
    pend_pos_d  = pend_pos_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    we          = 1'b0;
    waddr       = head_q;
    raddr       = slot(head_q, pos_q);

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          key_d  = in_key;
          trav_d = (cmd_i.mode == MODE_TRAVERSE);
          res_d  = '{kind: KIND_DONE, entry_value: '0, position: '0, occupancy: '0, last: 1'b1};
          unique case (cmd_i.mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
              res_valid_d = 1'b1;
              if (full) begin
                res_d.kind = KIND_FULL_ERR;
              end else begin
                we = 1'b1;
                if (cmd_i.mode == MODE_PUSH_FRONT) begin
                  waddr  = head_dec;
                  head_d = head_dec;
                end else begin
                  waddr = slot(head_q, count_q);
                end
                count_d = CW'(count_q + 1'b1);
              end
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
              if (empty) begin
                res_valid_d = 1'b1;
                res_d.kind  = KIND_EMPTY_ERR;
              end else begin
                // The ring pointers move now; the popped word arrives next cycle.
                if (cmd_i.mode == MODE_POP_FRONT) begin
                  raddr  = head_q;
                  head_d = head_inc;
                end else begin
                  raddr = slot(head_q, CW'(count_q - 1'b1));
                end
                if (count_q == CW'(1)) begin
                  head_d = '0;
                end
                count_d = CW'(count_q - 1'b1);
                state_d = S_POP;
              end
            end
            MODE_SEARCH, MODE_TRAVERSE: begin
              if (empty) begin
                res_valid_d = 1'b1;
                res_d.kind  = (cmd_i.mode == MODE_TRAVERSE) ? KIND_EMPTY_ERR : KIND_NO_MATCH;
              end else begin
                raddr   = head_q;
                pos_d   = CW'(1);
                pend_d  = 1'b0;
                state_d = S_SCAN;
              end
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        res_valid_d       = 1'b1;
        res_d.kind        = KIND_DONE;
        res_d.entry_value = to_out(rdata);
        res_d.position    = '0;
        res_d.last        = 1'b1;
        state_d           = S_IDLE;
      end
      S_SCAN: begin
        // The read data belongs to position pos_q; the next entry is being fetched.
        pos_d = CW'(pos_q + 1'b1);
        if (trav_q) begin
          res_valid_d       = 1'b1;
          res_d.kind        = KIND_LISTED;
          res_d.entry_value = to_out(rdata);
          res_d.position    = 6'(pos_q);
          res_d.last        = at_end;
          if (at_end) begin
            state_d = S_IDLE;
          end
        end else begin
          // A match is held back until the next match or the flush, so that the final one can carry the last flag.
          if (rdata == key_q) begin
            if (pend_q) begin
              res_valid_d       = 1'b1;
              res_d.kind        = KIND_MATCH;
              res_d.entry_value = to_out(pend_val_q);
              res_d.position    = 6'(pend_pos_q);
              res_d.last        = 1'b0;
            end
            pend_d     = 1'b1;
            pend_val_d = rdata;
            pend_pos_d = pos_q;
          end
          if (at_end) begin
            state_d = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        res_valid_d = 1'b1;
        res_d.last  = 1'b1;
        if (pend_q) begin
          res_d.kind        = KIND_MATCH;
          res_d.entry_value = to_out(pend_val_q);
          res_d.position    = 6'(pend_pos_q);
        end else begin
          res_d.kind        = KIND_NO_MATCH;
          res_d.entry_value = '0;
          res_d.position    = '0;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_d.occupancy = 6'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    trav_q     <= trav_d;
    key_q      <= key_d;
    pend_val_q <= pend_val_d;
    pend_pos_q <= pend_pos_d;
    res_q      <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

FILE: test/tb_bounded_deque_with_search.sv
// Self-checking testbench for the bounded deque with search: directed and random commands.
`timescale 1ns / 100ps

import bdq_pkg::*;

// Shadow copy of the deque that predicts every result and checks what the block returns.
class deque_shadow;
  logic [31:0] ring [DEPTH_DEF];
  int unsigned head;
  int unsigned count;
  out_t        pending_results [$];
  int unsigned mismatches;

  function new();
    head        = 0;
    count       = 0;
    mismatches  = 0;
  endfunction

  function void queue_result(logic [2:0] kind, logic [31:0] val, int unsigned pos, bit fin);
    out_t r;
    r.kind        = kind;
    r.entry_value = val;
    r.position    = pos[5:0];
    r.occupancy   = count[5:0];
    r.last        = fin;
    pending_results.push_back(r);
  endfunction

  // Works out the results of one accepted transfer and updates the shadow store.
  function void note_command(in_t c);
    logic [31:0] popped;
    int unsigned hits;
    case (c.mode)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (count == DEPTH_DEF) begin
          queue_result(KIND_FULL_ERR, '0, 0, 1'b1);
        end else begin
          if (c.mode == MODE_PUSH_FRONT) begin
            head       = (head + DEPTH_DEF - 1) % DEPTH_DEF;
            ring[head] = c.item_value;
          end else begin
            ring[(head + count) % DEPTH_DEF] = c.item_value;
          end
          count++;
          queue_result(KIND_DONE, '0, 0, 1'b1);
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        if (count == 0) begin
          queue_result(KIND_EMPTY_ERR, '0, 0, 1'b1);
        end else begin
          if (c.mode == MODE_POP_FRONT) begin
            popped = ring[head];
            head   = (head + 1) % DEPTH_DEF;
          end else begin
            popped = ring[(head + count - 1) % DEPTH_DEF];
          end
          count--;
          // Emptying the store puts the head back at slot zero.
          if (count == 0) head = 0;
          queue_result(KIND_DONE, popped, 0, 1'b0);
          pending_results[$].last = 1'b1;
        end
      end
      MODE_SEARCH: begin
        hits = 0;
        for (int unsigned i = 0; i < count; i++) begin
          if (ring[(head + i) % DEPTH_DEF] == c.item_value) begin
            queue_result(KIND_MATCH, ring[(head + i) % DEPTH_DEF], i + 1, 1'b0);
            hits++;
          end
        end
        if (hits == 0) queue_result(KIND_NO_MATCH, '0, 0, 1'b1);
        else pending_results[$].last = 1'b1;
      end
      MODE_TRAVERSE: begin
        if (count == 0) begin
          queue_result(KIND_EMPTY_ERR, '0, 0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < count; i++) begin
            queue_result(KIND_LISTED, ring[(head + i) % DEPTH_DEF], i + 1, i + 1 == count);
          end
        end
      end
      default: queue_result(KIND_DONE, '0, 0, 1'b1);
    endcase
  endfunction

  // Value held at a random position; only called when the store is not empty.
  function logic [31:0] held_value();
    return ring[(head + $urandom_range(0, count - 1)) % DEPTH_DEF];
  endfunction

  function void check_result(out_t got);
    out_t exp;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result with nothing expected: kind %0d value %h pos %0d occ %0d last %0b",
                 got.kind, got.entry_value, got.position, got.occupancy, got.last);
      return;
    end
    exp = pending_results.pop_front();
    if (got.kind !== exp.kind || got.entry_value !== exp.entry_value ||
        got.position !== exp.position || got.occupancy !== exp.occupancy ||
        got.last !== exp.last) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: expected kind %0d value %h pos %0d occ %0d last %0b",
                 exp.kind, exp.entry_value, exp.position, exp.occupancy, exp.last);
        $display("          got      kind %0d value %h pos %0d occ %0d last %0b",
                 got.kind, got.entry_value, got.position, got.occupancy, got.last);
      end
    end
  endfunction
endclass

module tb_bounded_deque_with_search;

  localparam int unsigned CYCLE_LIMIT = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_t         cmd_i = '0;
  logic        result_valid_o;
  out_t        result_o;

  deque_shadow book;
  int unsigned cycle_count = 0;
  bit          no_gaps = 1'b0;

  bounded_deque_with_search i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) book.check_result(result_o);
  end

  // Mostly short gaps, now and then a long one; none at all during quiet stretches.
  function automatic int unsigned gap_length();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Called just after a rising edge; returns after the edge that completes the transfer and any gap after it.
  task automatic send(input logic [2:0] mode, input logic [31:0] val);
    int unsigned gap;
    start      <= 1'b1;
    cmd_i.mode <= mode;
    cmd_i.item_value <= val;
    do @(posedge clk_i); while (busy);
    book.note_command('{mode: mode, item_value: val});
    gap = gap_length();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Half the picks come from four fixed values, which makes duplicate entries and repeated matches common.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    bit          filling;
    int unsigned r;
    logic [2:0]  mode;
    logic [31:0] val;

    book = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty-store errors, single-entry pops, extremes and unused modes.
    send(MODE_TRAVERSE, $urandom());
    send(MODE_POP_FRONT, $urandom());
    send(MODE_POP_BACK, $urandom());
    send(MODE_SEARCH, 32'h0000_0000);
    send(MODE_PUSH_BACK, 32'h7FFF_FFFF);
    send(MODE_POP_BACK, 32'h0000_0000);
    send(MODE_PUSH_FRONT, 32'h8000_0000);
    send(MODE_POP_FRONT, 32'hFFFF_FFFF);
    send(MODE_PUSH_FRONT, 32'h0000_0005);
    send(MODE_PUSH_BACK, 32'hFFFF_FFFF);
    send(MODE_PUSH_FRONT, 32'hFFFF_FFFF);
    send(MODE_PUSH_BACK, 32'h0000_0000);
    send(3'd6, 32'hA5A5_5A5A);
    send(3'd7, 32'h5A5A_A5A5);
    send(MODE_SEARCH, 32'hFFFF_FFFF);
    // The wanted value sits only in the last entry.
    send(MODE_SEARCH, 32'h0000_0000);
    send(MODE_SEARCH, 32'h0000_3039);
    send(MODE_TRAVERSE, 32'h0000_0000);
    send(MODE_POP_FRONT, 32'h0000_0000);
    send(MODE_POP_BACK, 32'h0000_0000);
    send(MODE_TRAVERSE, 32'h0000_0000);

    // Random part: alternate filling and draining phases so both full and empty are reached.
    filling = 1'b1;
    for (int n = 0; n < 350; n++) begin
      if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (filling && book.count == DEPTH_DEF && $urandom_range(0, 3) == 0) filling = 1'b0;
      if (!filling && book.count == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
      r   = $urandom_range(0, 99);
      val = pick_value();
      if (r < 3) begin
        mode = 3'($urandom_range(6, 7));
      end else if (r < 15) begin
        mode = MODE_SEARCH;
        if (book.count != 0 && $urandom_range(0, 1) == 0) val = book.held_value();
      end else if (r < 22) begin
        mode = MODE_TRAVERSE;
      end else if ((r < 75) == filling) begin
        mode = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
      end else begin
        mode = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
      end
      send(mode, val);
    end

    start <= 1'b0;
    while (book.pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (book.mismatches == 0 && book.pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
